/* rtl/rxls_pkg.sv */
// Package for the receive link statistics unit.
// Holds the event codes, the item and result payload types and the default counter width.
// No dependencies.
`timescale 1ns / 1ps

package rxls_pkg;

  localparam int unsigned CounterBitsDefault = 32;
  localparam int unsigned SeqBits = 16;
  localparam int unsigned OutCountBits = 32;

  localparam logic [2:0] OP_GOOD_FRAME = 3'd0;
  localparam logic [2:0] OP_LENGTH_ERR = 3'd1;
  localparam logic [2:0] OP_MAGIC_ERR  = 3'd2;
  localparam logic [2:0] OP_CRC_ERR    = 3'd3;
  localparam logic [2:0] OP_CLEAR_ALL  = 3'd4;

  typedef struct packed {
    logic [2:0]         op;
    logic [SeqBits-1:0] sequence_req;
  } rxls_item_t;

  typedef struct packed {
    logic [OutCountBits-1:0] frame_ok_count;
    logic [OutCountBits-1:0] length_error_count;
    logic [OutCountBits-1:0] magic_error_count;
    logic [OutCountBits-1:0] crc_error_count;
    logic [OutCountBits-1:0] duplicate_count;
    logic [OutCountBits-1:0] gap_total;
    logic [OutCountBits-1:0] out_of_order_count;
    logic [SeqBits-1:0]      previous_sequence;
    logic                    baseline_valid;
  } rxls_result_t;

  typedef struct packed {
    logic               duplicate;
    logic               reorder;
    logic [SeqBits-1:0] gap;
  } rxls_cmp_t;

endpackage

/* rtl/rxls_seq_compare.sv */
// Sequence number classifier for the receive link statistics unit.
// Compares a new sequence number with the previous one; uses rxls_pkg.
`timescale 1ns / 1ps

module rxls_seq_compare (
  input  logic [rxls_pkg::SeqBits-1:0] seq_i,
  input  logic [rxls_pkg::SeqBits-1:0] prev_seq_i,
  output rxls_pkg::rxls_cmp_t          cmp_o
);
  import rxls_pkg::*;

  logic [SeqBits-1:0] expected;

  // The next expected number wraps at the top of the sequence space, but the
  // forward compare below is a plain unsigned compare.
  assign expected = prev_seq_i + SeqBits'(1);

  always_comb begin
    cmp_o = '0;
    if (seq_i == prev_seq_i) begin
      cmp_o.duplicate = 1'b1;
    end else if (seq_i == expected) begin
      cmp_o = '0;
    end else if (seq_i > expected) begin
      cmp_o.gap = seq_i - expected;
    end else begin
      cmp_o.reorder = 1'b1;
    end
  end

endmodule

/* rtl/rx_link_statistics_unit.sv */
// Top level of the receive link statistics unit.
// Uses rxls_pkg and rxls_seq_compare.
// Usage:
// Each input transfer carries one receive event: a good frame with its
// sequence number, a length, magic or CRC error, or a clear of all counters.
// Every event yields exactly one output transfer with a snapshot of all
// counters taken after that event's update.
// The input transfer is captured in an input register; once the output
// register is free, the counters are updated and the snapshot is loaded into
// the output register. Throughput is one event per cycle while the receiver
// takes every result; the single counter update stage sets it.
// When the receiver stalls, the output holds and the input register fills;
// in_ready_o then drops until the output transfer completes.
// Reset clears all counters, the previous sequence number and the baseline
// flag, and empties both registers. Unknown event codes leave the counters
// unchanged and still return a snapshot.
`timescale 1ns / 1ps

module rx_link_statistics_unit #(
  parameter int unsigned COUNTER_BITS = rxls_pkg::CounterBitsDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  rxls_pkg::rxls_item_t   in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output rxls_pkg::rxls_result_t out_data_o
);
  import rxls_pkg::*;

  logic               item_valid_q, item_valid_d;
  rxls_item_t         item_q;
  logic               out_valid_q, out_valid_d;
  rxls_result_t       out_data_q, out_data_d;
  logic               advance;

  logic [COUNTER_BITS-1:0] frames_q, frames_d;
  logic [COUNTER_BITS-1:0] len_err_q, len_err_d;
  logic [COUNTER_BITS-1:0] magic_err_q, magic_err_d;
  logic [COUNTER_BITS-1:0] crc_err_q, crc_err_d;
  logic [COUNTER_BITS-1:0] dup_q, dup_d;
  logic [COUNTER_BITS-1:0] gap_q, gap_d;
  logic [COUNTER_BITS-1:0] reorder_q, reorder_d;
  logic [SeqBits-1:0]      prev_seq_q, prev_seq_d;
  logic                    baseline_q, baseline_d;
  rxls_cmp_t               cmp;

  assign advance    = item_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !item_valid_q || advance;

  always_comb begin
    item_valid_d = item_valid_q;
    if (in_valid_i && in_ready_o) begin
      item_valid_d = 1'b1;
    end else if (advance) begin
      item_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_data_i;
    end
  end

  rxls_seq_compare u_seq_compare (
    .seq_i      (item_q.sequence_req),
    .prev_seq_i (prev_seq_q),
    .cmp_o      (cmp)
  );

  always_comb begin
    frames_d    = frames_q;
    len_err_d   = len_err_q;
    magic_err_d = magic_err_q;
    crc_err_d   = crc_err_q;
    dup_d       = dup_q;
    gap_d       = gap_q;
    reorder_d   = reorder_q;
    prev_seq_d  = prev_seq_q;
    baseline_d  = baseline_q;
    if (advance) begin
      case (item_q.op)
        OP_GOOD_FRAME: begin
          frames_d   = frames_q + COUNTER_BITS'(1);
          prev_seq_d = item_q.sequence_req;
          baseline_d = 1'b1;
          if (baseline_q) begin
            dup_d     = dup_q + COUNTER_BITS'(cmp.duplicate);
            reorder_d = reorder_q + COUNTER_BITS'(cmp.reorder);
            gap_d     = gap_q + COUNTER_BITS'(cmp.gap);
          end
        end
        OP_LENGTH_ERR: len_err_d   = len_err_q + COUNTER_BITS'(1);
        OP_MAGIC_ERR:  magic_err_d = magic_err_q + COUNTER_BITS'(1);
        OP_CRC_ERR:    crc_err_d   = crc_err_q + COUNTER_BITS'(1);
        OP_CLEAR_ALL: begin
          frames_d    = '0;
          len_err_d   = '0;
          magic_err_d = '0;
          crc_err_d   = '0;
          dup_d       = '0;
          gap_d       = '0;
          reorder_d   = '0;
          prev_seq_d  = '0;
          baseline_d  = 1'b0;
        end
        default: baseline_d = baseline_q;
      endcase
    end
  end

  always_comb begin
    out_data_d.frame_ok_count     = OutCountBits'(frames_d);
    out_data_d.length_error_count = OutCountBits'(len_err_d);
    out_data_d.magic_error_count  = OutCountBits'(magic_err_d);
    out_data_d.crc_error_count    = OutCountBits'(crc_err_d);
    out_data_d.duplicate_count    = OutCountBits'(dup_d);
    out_data_d.gap_total          = OutCountBits'(gap_d);
    out_data_d.out_of_order_count = OutCountBits'(reorder_d);
    out_data_d.previous_sequence  = prev_seq_d;
    out_data_d.baseline_valid     = baseline_d;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      frames_q     <= '0;
      len_err_q    <= '0;
      magic_err_q  <= '0;
      crc_err_q    <= '0;
      dup_q        <= '0;
      gap_q        <= '0;
      reorder_q    <= '0;
      prev_seq_q   <= '0;
      baseline_q   <= 1'b0;
    end else begin
      item_valid_q <= item_valid_d;
      out_valid_q  <= out_valid_d;
      frames_q     <= frames_d;
      len_err_q    <= len_err_d;
      magic_err_q  <= magic_err_d;
      crc_err_q    <= crc_err_d;
      dup_q        <= dup_d;
      gap_q        <= gap_d;
      reorder_q    <= reorder_d;
      prev_seq_q   <= prev_seq_d;
      baseline_q   <= baseline_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTH
  a_cmp_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_valid_q |-> $onehot0({cmp.duplicate, cmp.reorder, cmp.gap != '0}))
    else $error("sequence compare flagged more than one outcome");

  a_no_baseline_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.baseline_valid) |->
      (out_data_o.previous_sequence == '0 && out_data_o.frame_ok_count == '0))
    else $error("snapshot without baseline shows a recorded frame");

  a_good_sets_baseline: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && item_q.op == OP_GOOD_FRAME) |=> (baseline_q && out_valid_o))
    else $error("good frame did not set the baseline");

  a_clear_zeroes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && item_q.op == OP_CLEAR_ALL) |=>
      (out_valid_o && out_data_o.frame_ok_count == '0 && out_data_o.gap_total == '0))
    else $error("clear did not zero the counters");
`endif

endmodule

/* tb/tb_rx_link_statistics_unit.sv */
// Testbench for rx_link_statistics_unit: drives receive events and checks every counter snapshot
// against a behavioral model of the link statistics kept inside this file.
// Depends on rxls_pkg and the rx_link_statistics_unit RTL.
`timescale 1ns / 1ps

module tb_rx_link_statistics_unit;
  import rxls_pkg::*;

  localparam int unsigned CNT_W = CounterBitsDefault;
  localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] OP_UNUSED_MID   = 3'd6;
  localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam logic [SeqBits-1:0] SEQ_TOP = '1;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_valid = 1'b0;
  logic         in_ready;
  rxls_item_t   in_data = '0;
  logic         out_valid;
  logic         out_ready = 1'b0;
  rxls_result_t out_data;

  rx_link_statistics_unit uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [CNT_W-1:0]   good_frames;
  logic [CNT_W-1:0]   length_errors;
  logic [CNT_W-1:0]   magic_errors;
  logic [CNT_W-1:0]   crc_errors;
  logic [CNT_W-1:0]   duplicate_frames;
  logic [CNT_W-1:0]   missing_total;
  logic [CNT_W-1:0]   reordered_frames;
  logic [SeqBits-1:0] prev_seq;
  logic               have_baseline;

  rxls_result_t snapshot_q[$];
  rxls_result_t want;
  int errors = 0;
  int n_sent = 0;
  int n_good = 0;
  int n_clear = 0;
  int n_checked = 0;
  int idle_pct = 0;
  int out_stall = 0;
  int quiet_cycles = 0;

  task automatic clear_link_stats();
    good_frames = '0;
    length_errors = '0;
    magic_errors = '0;
    crc_errors = '0;
    duplicate_frames = '0;
    missing_total = '0;
    reordered_frames = '0;
    prev_seq = '0;
    have_baseline = 1'b0;
  endtask

  task automatic update_link_stats(input rxls_item_t item);
    logic [SeqBits-1:0] next_seq;
    rxls_result_t snap;
    next_seq = prev_seq + 1'b1;
    case (item.op)
      OP_GOOD_FRAME: begin
        n_good++;
        good_frames = good_frames + 1'b1;
        if (have_baseline) begin
          if (item.sequence_req == prev_seq) begin
            duplicate_frames = duplicate_frames + 1'b1;
          end else if (item.sequence_req > next_seq) begin
            missing_total = missing_total + CNT_W'(item.sequence_req - next_seq);
          end else if (item.sequence_req < next_seq) begin
            reordered_frames = reordered_frames + 1'b1;
          end
        end
        have_baseline = 1'b1;
        prev_seq = item.sequence_req;
      end
      OP_LENGTH_ERR: length_errors = length_errors + 1'b1;
      OP_MAGIC_ERR:  magic_errors = magic_errors + 1'b1;
      OP_CRC_ERR:    crc_errors = crc_errors + 1'b1;
      OP_CLEAR_ALL: begin
        n_clear++;
        clear_link_stats();
      end
      default: ;
    endcase
    snap.frame_ok_count     = good_frames[OutCountBits-1:0];
    snap.length_error_count = length_errors[OutCountBits-1:0];
    snap.magic_error_count  = magic_errors[OutCountBits-1:0];
    snap.crc_error_count    = crc_errors[OutCountBits-1:0];
    snap.duplicate_count    = duplicate_frames[OutCountBits-1:0];
    snap.gap_total          = missing_total[OutCountBits-1:0];
    snap.out_of_order_count = reordered_frames[OutCountBits-1:0];
    snap.previous_sequence  = prev_seq;
    snap.baseline_valid     = have_baseline;
    snapshot_q.push_back(snap);
  endtask

  function automatic int idle_gap();
    if ($urandom_range(99) >= idle_pct) return 0;
    if ($urandom_range(99) < 85) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  task automatic send_event(input logic [2:0] op, input logic [SeqBits-1:0] seq);
    rxls_item_t item;
    int gap;
    item.op = op;
    item.sequence_req = seq;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    update_link_stats(item);
    n_sent++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] got_val);
    if (exp_val !== got_val) begin
      errors++;
      $display("%0t ns: %s expected %0h, got %0h", $time, name, exp_val, got_val);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (snapshot_q.size() == 0) begin
          errors++;
          $display("%0t ns: unexpected snapshot, expected none, got %h", $time, out_data);
        end else begin
          want = snapshot_q.pop_front();
          compare_field("frame_ok_count", want.frame_ok_count, out_data.frame_ok_count);
          compare_field("length_error_count", want.length_error_count,
                        out_data.length_error_count);
          compare_field("magic_error_count", want.magic_error_count,
                        out_data.magic_error_count);
          compare_field("crc_error_count", want.crc_error_count, out_data.crc_error_count);
          compare_field("duplicate_count", want.duplicate_count, out_data.duplicate_count);
          compare_field("gap_total", want.gap_total, out_data.gap_total);
          compare_field("out_of_order_count", want.out_of_order_count,
                        out_data.out_of_order_count);
          compare_field("previous_sequence", 32'(want.previous_sequence),
                        32'(out_data.previous_sequence));
          compare_field("baseline_valid", 32'(want.baseline_valid),
                        32'(out_data.baseline_valid));
          n_checked++;
        end
      end
      if (out_stall == 0) out_stall = idle_gap();
      if (out_stall > 0) begin
        out_ready <= 1'b0;
        out_stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Timeout after %0d cycles without a transfer.", quiet_cycles);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  task automatic test_error_events();
    send_event(OP_LENGTH_ERR, 16'h0000);
    send_event(OP_MAGIC_ERR, SEQ_TOP);
    send_event(OP_CRC_ERR, 16'h5A5A);
    send_event(OP_UNUSED_FIRST, SEQ_TOP);
    send_event(OP_UNUSED_MID, 16'h0000);
    send_event(OP_UNUSED_LAST, 16'hA5A5);
  endtask

  task automatic test_sequence_compare();
    send_event(OP_GOOD_FRAME, 16'd100);
    send_event(OP_GOOD_FRAME, 16'd101);
    send_event(OP_GOOD_FRAME, 16'd101);
    send_event(OP_GOOD_FRAME, 16'd110);
    send_event(OP_GOOD_FRAME, 16'd105);
  endtask

  task automatic test_sequence_wrap();
    send_event(OP_CLEAR_ALL, 16'h1234);
    send_event(OP_GOOD_FRAME, SEQ_TOP);
    send_event(OP_GOOD_FRAME, SEQ_TOP);
    send_event(OP_GOOD_FRAME, 16'd0);
    send_event(OP_CLEAR_ALL, SEQ_TOP);
    send_event(OP_GOOD_FRAME, SEQ_TOP);
    send_event(OP_GOOD_FRAME, 16'd1234);
    send_event(OP_GOOD_FRAME, 16'd0);
  endtask

  task automatic test_clear_and_rebaseline();
    send_event(OP_CRC_ERR, 16'd7);
    send_event(OP_CLEAR_ALL, 16'd0);
    send_event(OP_GOOD_FRAME, 16'd0);
    send_event(OP_GOOD_FRAME, 16'd0);
  endtask

  task automatic test_random_traffic(input int count, input int pct);
    int pick;
    logic [2:0] op;
    logic [SeqBits-1:0] seq;
    idle_pct = pct;
    repeat (count) begin
      pick = $urandom_range(99);
      seq = SeqBits'($urandom);
      if (pick < 75) begin
        op = OP_GOOD_FRAME;
        pick = $urandom_range(99);
        if (pick < 55) seq = prev_seq + 1'b1;
        else if (pick < 65) seq = prev_seq;
        else if (pick < 75) seq = prev_seq + SeqBits'($urandom_range(20, 2));
        else if (pick < 83) seq = prev_seq - SeqBits'($urandom_range(20, 1));
        else if (pick < 95 && pick >= 90) seq = ($urandom_range(1)) ? SEQ_TOP : '0;
        else if (pick >= 95) seq = prev_seq + SeqBits'($urandom_range(3000, 1));
      end else if (pick < 81) begin
        op = OP_LENGTH_ERR;
      end else if (pick < 87) begin
        op = OP_MAGIC_ERR;
      end else if (pick < 93) begin
        op = OP_CRC_ERR;
      end else if (pick < 96) begin
        op = OP_CLEAR_ALL;
      end else begin
        op = 3'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST));
      end
      send_event(op, seq);
    end
  endtask

  initial begin
    clear_link_stats();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    idle_pct = 25;
    test_error_events();
    test_sequence_compare();
    test_sequence_wrap();
    test_clear_and_rebaseline();
    test_random_traffic(150, 0);
    test_random_traffic(300, 15);
    test_random_traffic(250, 45);
    in_valid <= 1'b0;
    while (snapshot_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Run covered %0d events: %0d good frames, %0d clears, %0d snapshots checked.",
             n_sent, n_good, n_clear, n_checked);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/rxls_pkg.sv
rtl/rxls_seq_compare.sv
rtl/rx_link_statistics_unit.sv
tb/tb_rx_link_statistics_unit.sv
